// ===== hw/rtl/ddd_pkg.sv =====
// shared types, constants and the month table for the date difference block
// used by ddd_ctrl, ddd_datapath and date_difference_in_days
package ddd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 23;

  // divide by 100 as (n >> 2) * 5243 >> 17, exact for n below 2**14
  localparam int QUOT_W      = 8;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 17;
  localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;

  localparam logic [COUNT_W-1:0] DAYS_PER_YEAR = 23'd365;
  localparam logic [MONTH_W-1:0] MONTH_MARCH   = 4'd3;

  typedef struct packed {
    logic load;       // capture a new request
    logic sel;        // 0 start date, 1 end date
    logic div_p;      // register (year-1)/100
    logic div_y;      // register year/100
    logic acc_first;  // acc = -value
    logic acc_next;   // acc = acc + value
  } cmd_t;

  typedef struct packed {
    logic order_err;
  } status_t;

  // days in the months before the given one, non-leap
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    begin
      case (m) inside
        4'd0, 4'd1: n = 9'd0;
        4'd2:       n = 9'd31;
        4'd3:       n = 9'd59;
        4'd4:       n = 9'd90;
        4'd5:       n = 9'd120;
        4'd6:       n = 9'd151;
        4'd7:       n = 9'd181;
        4'd8:       n = 9'd212;
        4'd9:       n = 9'd243;
        4'd10:      n = 9'd273;
        4'd11:      n = 9'd304;
        default:    n = 9'd334;  // december and beyond
      endcase
      return n;
    end
  endfunction

endpackage

// ===== hw/rtl/ddd_ctrl.sv =====
// sequencer for the date difference block: handshakes and datapath commands
// depends on ddd_pkg
module ddd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output ddd_pkg::cmd_t    cmd,
  input  ddd_pkg::status_t status
);
  import ddd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV_P = 3'd1;
  localparam logic [2:0] S_DIV_Y = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       sel;
  logic       sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd        = '0;
    cmd.sel    = sel;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          sel_next   = 1'b0;
          state_next = S_DIV_P;
        end
      end
      S_DIV_P: begin
        if (status.order_err) begin
          state_next = S_DONE;
        end else begin
          cmd.div_p  = 1'b1;
          state_next = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        cmd.div_y  = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_first = !sel;
        cmd.acc_next  = sel;
        if (sel) begin
          state_next = S_DONE;
        end else begin
          sel_next   = 1'b1;
          state_next = S_DIV_P;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/ddd_datapath.sv =====
// request registers, shared divide-by-100 unit and day accumulator
// depends on ddd_pkg
module ddd_datapath (
  input  logic                                clk,
  input  ddd_pkg::cmd_t                       cmd,
  output ddd_pkg::status_t                    status,
  input  logic [ddd_pkg::YEAR_W-1:0]          start_year,
  input  logic [ddd_pkg::MONTH_W-1:0]         start_month,
  input  logic [ddd_pkg::DAY_W-1:0]           start_day,
  input  logic [ddd_pkg::YEAR_W-1:0]          end_year,
  input  logic [ddd_pkg::MONTH_W-1:0]         end_month,
  input  logic [ddd_pkg::DAY_W-1:0]           end_day,
  output logic signed [ddd_pkg::COUNT_W-1:0]  day_count,
  output logic                                order_error
);
  import ddd_pkg::*;

  logic [YEAR_W-1:0]  y1, y2;
  logic [MONTH_W-1:0] m1, m2;
  logic [DAY_W-1:0]   d1, d2;
  logic               err;
  logic [QUOT_W-1:0]  cp;   // (year-1)/100
  logic [QUOT_W-1:0]  cy;   // year/100
  logic [COUNT_W-1:0] acc;

  logic [YEAR_W-1:0]          y;
  logic [MONTH_W-1:0]         m;
  logic [DAY_W-1:0]           d;
  logic [YEAR_W-1:0]          p;
  logic [YEAR_W-1:0]          div_in;
  logic [YEAR_W-3:0]          div_q4;
  logic [YEAR_W-2+RECIP_W-1:0] prod;
  logic [QUOT_W-1:0]          quot;
  logic                       leap;
  logic [COUNT_W-1:0]         year_term;
  logic [COUNT_W-1:0]         doy;
  logic [COUNT_W-1:0]         value;

  assign y = cmd.sel ? y2 : y1;
  assign m = cmd.sel ? m2 : m1;
  assign d = cmd.sel ? d2 : d1;
  assign p = y - YEAR_W'(1);

  // shared divide by 100
  assign div_in = cmd.div_p ? p : y;
  assign div_q4 = div_in[YEAR_W-1:2];
  assign prod   = YEAR_W'(div_q4) * (YEAR_W-2+RECIP_W)'(RECIP_25);
  assign quot   = prod[RECIP_SHIFT +: QUOT_W];

  // year/100 differs from (year-1)/100 exactly on century years
  assign leap = (y == '0) ||
                ((y[1:0] == 2'b00) && (cy == cp)) ||
                (cy[QUOT_W-1:2] != cp[QUOT_W-1:2]);

  always_comb begin
    if (y == '0) begin
      year_term = '0;
    end else begin
      year_term = COUNT_W'(y) * DAYS_PER_YEAR
                + COUNT_W'(p[YEAR_W-1:2])
                - COUNT_W'(cp)
                + COUNT_W'(cp[QUOT_W-1:2])
                + COUNT_W'(1);
    end
    doy   = COUNT_W'(days_before_month(m))
          + COUNT_W'(leap && (m >= MONTH_MARCH))
          + COUNT_W'(d);
    value = year_term + doy;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y1  <= start_year;
      m1  <= start_month;
      d1  <= start_day;
      y2  <= end_year;
      m2  <= end_month;
      d2  <= end_day;
      err <= end_year < start_year;
    end
    if (cmd.div_p) cp <= quot;
    if (cmd.div_y) cy <= quot;
    if (cmd.acc_first) acc <= COUNT_W'(0) - value;
    else if (cmd.acc_next) acc <= acc + value;
  end

  assign status.order_err = err;
  assign day_count        = err ? '0 : $signed(acc);
  assign order_error      = err;

endmodule

// ===== hw/rtl/date_difference_in_days.sv =====
// top level of the gregorian date difference block
// depends on ddd_pkg, ddd_ctrl and ddd_datapath
//
//   channel  signals                     carries
//   in       in_valid / in_ready         start and end dates (year, month, day)
//   out      out_valid / out_ready       day_count, order_error
//
// after accept, the start date and then the end date each pass through S_DIV_P
// ((year-1)/100) and S_DIV_Y (year/100) in the shared divide unit, then S_ACC;
// out_valid rises in S_DONE; with out_ready high the sequencer goes back to idle
// an order error skips the arithmetic and goes from S_DIV_P straight to S_DONE
// one request at a time: in_ready is high only while idle
// the result holds while out_ready is low; rst returns the sequencer to idle
module date_difference_in_days (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ddd_pkg::YEAR_W-1:0]          start_year,
  input  logic [ddd_pkg::MONTH_W-1:0]         start_month,
  input  logic [ddd_pkg::DAY_W-1:0]           start_day,
  input  logic [ddd_pkg::YEAR_W-1:0]          end_year,
  input  logic [ddd_pkg::MONTH_W-1:0]         end_month,
  input  logic [ddd_pkg::DAY_W-1:0]           end_day,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ddd_pkg::COUNT_W-1:0]  day_count,
  output logic                                order_error
);
  import ddd_pkg::*;

  cmd_t    cmd;
  status_t status;

  ddd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  ddd_datapath u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .start_year  (start_year),
    .start_month (start_month),
    .start_day   (start_day),
    .end_year    (end_year),
    .end_month   (end_month),
    .end_day     (end_day),
    .day_count   (day_count),
    .order_error (order_error)
  );

endmodule
